// File: hdl/stq_pkg.sv
// Package for the sorted timer queue: request, status, cell and state codes.
// No dependencies; compiled first.
package stq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int ID_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        REQ_SET  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_SET_OK    = 3'd0,
        ST_FULL      = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_EXPIRED   = 3'd4,
        ST_NO_EXPIRY = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SET,
        CELL_DEL,
        CELL_DEC,
        CELL_POP
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_EXPIRE
    } state_t;

endpackage

// File: hdl/stq_if.sv
// Handshake interfaces for the request and response channels of the timer queue.
// Depends on nothing; field widths are fixed by the channel format.
interface stq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] duration;
    logic [15:0] timer_id;

    modport source (output valid, output req_type, output duration, output timer_id,
                    input ready);
    modport sink (input valid, input req_type, input duration, input timer_id,
                  output ready);
endinterface

interface stq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] result_id;
    logic        last;

    modport source (output valid, output status, output result_id, output last,
                    input ready);
    modport sink (input valid, input status, input result_id, input last,
                  output ready);
endinterface

// File: hdl/stq_cell.sv
// One slot of the timer queue chain: holds a remaining time, an identifier and
// a valid flag, and trades entries with its neighbors. Depends on stq_pkg.
module stq_cell
    import stq_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_op_t             op,
    input  logic [TIME_BITS-1:0] new_time,
    input  logic [ID_BITS-1:0]   new_id,
    input  logic                 keep_in,
    output logic                 keep_out,
    input  logic                 seen_in,
    output logic                 seen_out,
    input  logic [TIME_BITS-1:0] left_time,
    input  logic [ID_BITS-1:0]   left_id,
    input  logic                 left_valid,
    input  logic [TIME_BITS-1:0] right_time,
    input  logic [ID_BITS-1:0]   right_id,
    input  logic                 right_valid,
    output logic [TIME_BITS-1:0] time_q,
    output logic [ID_BITS-1:0]   id_q,
    output logic                 valid_q
);

    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic                 valid_reg, valid_next;
    logic                 keep;
    logic                 match;

    // An entry stays put on insertion when it is strictly earlier than the new one.
    assign keep     = valid_reg && (time_reg < new_time);
    assign keep_out = keep;
    assign match    = valid_reg && (id_reg == new_id);
    assign seen_out = seen_in || match;

    always_comb
    begin
        time_next  = time_reg;
        id_next    = id_reg;
        valid_next = valid_reg;
        case (op)
            CELL_SET:
            begin
                if (!keep && keep_in)
                begin
                    time_next  = new_time;
                    id_next    = new_id;
                    valid_next = 1'b1;
                end
                else if (!keep)
                begin
                    time_next  = left_time;
                    id_next    = left_id;
                    valid_next = left_valid;
                end
            end
            CELL_DEL, CELL_POP:
            begin
                if (op == CELL_POP || seen_out)
                begin
                    time_next  = right_time;
                    id_next    = right_id;
                    valid_next = right_valid;
                end
            end
            CELL_DEC:
            begin
                if (time_reg != '0)
                begin
                    time_next = time_reg - TIME_BITS'(1);
                end
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg  <= '0;
            id_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            time_reg  <= time_next;
            id_reg    <= id_next;
            valid_reg <= valid_next;
        end
    end

    assign time_q  = time_reg;
    assign id_q    = id_reg;
    assign valid_q = valid_reg;

endmodule

// File: hdl/sorted_timer_queue.sv
// Sorted timer queue: a chain of DEPTH cells kept packed and sorted by remaining time.
// Set and delete each give their single response item from an output register;
// one request per cycle while responses are taken and no tick is expiring entries.
// A tick decrements every cell; if the head is due, the chain then pops its head entry
// once per response item until the next entry is not due.
// Reset (rst_n, asynchronous, active low) empties every cell and clears the id counter.
module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    stq_req_if.sink   req,
    stq_rsp_if.source rsp
);

    // Cell array views and the neighbor chains that run through it.
    logic [TIME_BITS-1:0] cell_time [DEPTH];
    logic [ID_BITS-1:0]   cell_id   [DEPTH];
    logic                 cell_valid [DEPTH];
    logic [DEPTH:0]       keep_chain;
    logic [DEPTH:0]       seen_chain;

    cell_op_t             op;
    logic [TIME_BITS-1:0] bcast_time;
    logic [ID_BITS-1:0]   bcast_id;

    state_t               state_reg, state_next;
    logic [ID_BITS-1:0]   id_cnt_reg, id_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [15:0]          out_id_reg, out_id_next;
    logic                 out_last_reg, out_last_next;

    logic                 out_free;
    logic                 accept;
    logic [ID_BITS-1:0]   want_id;
    logic [ID_BITS-1:0]   fresh_id;
    logic                 head_due;
    logic                 second_due;

    assign keep_chain[0] = 1'b1;
    assign seen_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [TIME_BITS-1:0] lt, rt;
            logic [ID_BITS-1:0]   li, ri;
            logic                 lv, rv;

            if (g == 0)
            begin : g_left_edge
                assign lt = '0;
                assign li = '0;
                assign lv = 1'b0;
            end
            else
            begin : g_left
                assign lt = cell_time[g-1];
                assign li = cell_id[g-1];
                assign lv = cell_valid[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_right_edge
                assign rt = '0;
                assign ri = '0;
                assign rv = 1'b0;
            end
            else
            begin : g_right
                assign rt = cell_time[g+1];
                assign ri = cell_id[g+1];
                assign rv = cell_valid[g+1];
            end

            stq_cell #(
                .TIME_BITS (TIME_BITS),
                .ID_BITS   (ID_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .new_time    (bcast_time),
                .new_id      (bcast_id),
                .keep_in     (keep_chain[g]),
                .keep_out    (keep_chain[g+1]),
                .seen_in     (seen_chain[g]),
                .seen_out    (seen_chain[g+1]),
                .left_time   (lt),
                .left_id     (li),
                .left_valid  (lv),
                .right_time  (rt),
                .right_id    (ri),
                .right_valid (rv),
                .time_q      (cell_time[g]),
                .id_q        (cell_id[g]),
                .valid_q     (cell_valid[g])
            );
        end
    endgenerate

    // The output register can take a new item when empty or when it is drained this cycle.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign want_id  = ID_BITS'(req.timer_id);
    // Identifiers count up from one and skip zero when the counter wraps.
    assign fresh_id = ((id_cnt_reg + ID_BITS'(1)) == '0) ? ID_BITS'(1)
                                                          : (id_cnt_reg + ID_BITS'(1));

    // A tick expires every leading entry with one tick or less left. During the
    // expiry phase the times are already decremented, so due means zero.
    assign head_due   = cell_valid[0] && (cell_time[0] <= TIME_BITS'(1));
    assign second_due = cell_valid[1] && (cell_time[1] == '0);

    always_comb
    begin
        state_next      = state_reg;
        id_cnt_next     = id_cnt_reg;
        op              = CELL_HOLD;
        bcast_time      = TIME_BITS'(req.duration);
        bcast_id        = want_id;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type_t'(req.req_type))
                        REQ_SET:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (cell_valid[DEPTH-1])
                            begin
                                out_status_next = ST_FULL;
                                out_id_next     = '0;
                            end
                            else
                            begin
                                op              = CELL_SET;
                                bcast_id        = fresh_id;
                                id_cnt_next     = fresh_id;
                                out_status_next = ST_SET_OK;
                                out_id_next     = 16'(fresh_id);
                            end
                        end
                        REQ_DEL:
                        begin
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                            if (want_id != '0 && seen_chain[DEPTH])
                            begin
                                op              = CELL_DEL;
                                out_status_next = ST_DELETED;
                                out_id_next     = 16'(want_id);
                            end
                            else
                            begin
                                out_status_next = ST_NOT_FOUND;
                                out_id_next     = '0;
                            end
                        end
                        REQ_TICK:
                        begin
                            op = CELL_DEC;
                            if (head_due)
                            begin
                                state_next = S_EXPIRE;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = ST_NO_EXPIRY;
                                out_id_next     = '0;
                                out_last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            op = CELL_HOLD;
                        end
                    endcase
                end
            end
            S_EXPIRE:
            begin
                // Pop the head and report it; the last item is the one whose
                // successor is not due.
                if (out_free)
                begin
                    op              = CELL_POP;
                    out_valid_next  = 1'b1;
                    out_status_next = ST_EXPIRED;
                    out_id_next     = 16'(cell_id[0]);
                    out_last_next   = !second_due;
                    if (!second_due)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            id_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            id_cnt_reg    <= id_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.result_id = out_id_reg;
    assign rsp.last      = out_last_reg;

endmodule

// File: test/sorted_timer_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timer_queue: directed and random set/delete/tick
// requests, each response item checked against an in-bench table model.
// Depends on stq_pkg, the stq_req_if/stq_rsp_if interfaces and the sorted_timer_queue RTL.
module sorted_timer_queue_test;
    import stq_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;
    localparam int RANDOM_REQUESTS = 320;
    localparam int REPORT_LIMIT    = 10;

    // One request item as the sender queues it.
    typedef struct {
        req_type_t   kind;
        logic [15:0] duration;
        logic [15:0] timer_id;
    } request_t;

    // One response item as the table model predicts it.
    typedef struct {
        status_t     status;
        logic [15:0] result_id;
        logic        last;
    } response_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycles = 0;
    logic        calm;
    int          mismatches = 0;

    stq_req_if req_ch();
    stq_rsp_if rsp_ch();

    sorted_timer_queue DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Timer table model. Entries 0 .. armed-1 are live and sorted by remaining ticks,
    // exactly like the cell chain inside the block.
    logic [15:0] ticks_left  [DEPTH];
    logic [15:0] timer_owner [DEPTH];
    int          armed;
    logic [15:0] last_issued_id;

    request_t  request_backlog[$];
    response_t awaited_responses[$];

    // Both sides stop idling while calm is high, a window that recurs with the cycle counter,
    // so that back-to-back traffic is seen as well as gaps on every phase of a tick.
    assign calm = (cycles % 2048) < 300;

    task automatic push_response(input status_t status, input logic [15:0] ident,
                                 input logic last);
        response_t r;
        r.status    = status;
        r.result_id = ident;
        r.last      = last;
        awaited_responses.push_back(r);
    endtask

    // Applies one accepted request to the table model and queues the response items
    // that it causes.
    task automatic apply_request(input request_t r);
        int          pos;
        int          hit;
        int          due;
        int          i;
        logic [15:0] fresh;
        case (r.kind)
            REQ_SET:
            begin
                if (armed >= DEPTH)
                begin
                    // A full table refuses the timer and the id counter stays put.
                    push_response(ST_FULL, 16'd0, 1'b1);
                end
                else
                begin
                    // Identifiers count up from 1 and skip 0 when they wrap.
                    fresh = last_issued_id + 16'd1;
                    if (fresh == 16'd0)
                        fresh = 16'd1;
                    last_issued_id = fresh;
                    // A new timer goes ahead of every entry with the same time.
                    pos = 0;
                    while (pos < armed && ticks_left[pos] < r.duration)
                        pos++;
                    for (i = armed; i > pos; i--)
                    begin
                        ticks_left[i]  = ticks_left[i - 1];
                        timer_owner[i] = timer_owner[i - 1];
                    end
                    ticks_left[pos]  = r.duration;
                    timer_owner[pos] = fresh;
                    armed++;
                    push_response(ST_SET_OK, fresh, 1'b1);
                end
            end
            REQ_DEL:
            begin
                // Identifier 0 never matches; among duplicates the first in sorted
                // order goes.
                hit = -1;
                if (r.timer_id != 16'd0)
                begin
                    for (i = 0; i < armed && hit < 0; i++)
                        if (timer_owner[i] == r.timer_id)
                            hit = i;
                end
                if (hit < 0)
                begin
                    push_response(ST_NOT_FOUND, 16'd0, 1'b1);
                end
                else
                begin
                    for (i = hit; i + 1 < armed; i++)
                    begin
                        ticks_left[i]  = ticks_left[i + 1];
                        timer_owner[i] = timer_owner[i + 1];
                    end
                    armed--;
                    push_response(ST_DELETED, r.timer_id, 1'b1);
                end
            end
            REQ_TICK:
            begin
                // Entries at 0 or 1 expire now; since the table is sorted they form
                // its head.
                due = 0;
                while (due < armed && ticks_left[due] <= 16'd1)
                    due++;
                if (due == 0)
                begin
                    for (i = 0; i < armed; i++)
                        ticks_left[i] = ticks_left[i] - 16'd1;
                    push_response(ST_NO_EXPIRY, 16'd0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < due; i++)
                        push_response(ST_EXPIRED, timer_owner[i], i == due - 1);
                    for (i = due; i < armed; i++)
                    begin
                        ticks_left[i - due]  = ticks_left[i] - 16'd1;
                        timer_owner[i - due] = timer_owner[i];
                    end
                    armed -= due;
                end
            end
            default:
            begin
                // The unused request code is swallowed without a response.
            end
        endcase
    endtask

    // Request driver: holds valid until the item is taken, then either presents the
    // next backlog item or idles, at random outside the calm window or when the backlog is empty.
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        request_t taken;
        request_t next_req;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                taken.kind     = req_type_t'(req_ch.req_type);
                taken.duration = req_ch.duration;
                taken.timer_id = req_ch.timer_id;
                apply_request(taken);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_backlog.size() > 0 && (calm || $urandom_range(99) >= 20))
                begin
                    next_req = request_backlog.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= next_req.kind;
                    req_ch.duration <= next_req.duration;
                    req_ch.timer_id <= next_req.timer_id;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: compares each taken response item with the oldest prediction
    // and stalls the block at random through ready.
    always @(posedge clk or negedge rst_n)
    begin : response_monitor
        response_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: unexpected response item status %0d id %0d last %0d",
                                 $realtime, rsp_ch.status, rsp_ch.result_id, rsp_ch.last);
                    mismatches++;
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.result_id !== want.result_id
                        || rsp_ch.last !== want.last)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: expected status %0d id %0d last %0d, got %0d %0d %0d",
                                     $realtime, want.status, want.result_id, want.last,
                                     rsp_ch.status, rsp_ch.result_id, rsp_ch.last);
                        mismatches++;
                    end
                end
            end
            rsp_ch.ready <= calm || $urandom_range(99) >= 20;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("sorted_timer_queue: mismatch");
            $finish;
        end
    end

    task automatic queue_request(input req_type_t kind, input logic [15:0] duration,
                                 input logic [15:0] timer_id);
        request_t r;
        r.kind     = kind;
        r.duration = duration;
        r.timer_id = timer_id;
        request_backlog.push_back(r);
    endtask

    // Returns once every queued item is taken and every predicted response has come.
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (request_backlog.size() != 0 || req_ch.valid || awaited_responses.size() != 0);
    endtask

    // Queues a batch of random requests. Deletes mostly aim at timers that are live
    // or about to be set, judged from the table model at the start of the batch.
    task automatic queue_random_batch(input int batch, inout int counted);
        logic [15:0] live[$];
        logic [15:0] guess;
        logic [15:0] dur;
        logic [15:0] victim;
        int          occupancy;
        int          pick;
        int          roll;
        int          k;
        for (k = 0; k < armed; k++)
            live.push_back(timer_owner[k]);
        guess     = last_issued_id;
        occupancy = armed;
        for (k = 0; k < batch; k++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                // Mostly short timers so that ticks expire them; some long ones fill
                // the table up.
                pick = $urandom_range(99);
                if (pick < 60)
                    dur = 16'($urandom_range(6, 0));
                else if (pick < 75)
                    dur = 16'($urandom_range(40, 7));
                else if (pick < 90)
                    dur = 16'($urandom_range(16'hFFFF, 0));
                else
                    dur = (pick < 95) ? 16'hFFFF : 16'hFFFE;
                queue_request(REQ_SET, dur, 16'($urandom_range(16'hFFFF, 0)));
                if (occupancy < DEPTH)
                begin
                    guess = guess + 16'd1;
                    if (guess == 16'd0)
                        guess = 16'd1;
                    live.push_back(guess);
                    occupancy++;
                end
                counted++;
            end
            else if (roll < 75)
            begin
                if (live.size() > 0 && $urandom_range(99) < 80)
                begin
                    pick   = $urandom_range(live.size() - 1, 0);
                    victim = live[pick];
                    live.delete(pick);
                    occupancy--;
                end
                else if ($urandom_range(9) == 0)
                begin
                    victim = 16'd0;
                end
                else
                begin
                    victim = 16'($urandom_range(16'hFFFF, 0));
                end
                queue_request(REQ_DEL, 16'($urandom_range(16'hFFFF, 0)), victim);
                counted++;
            end
            else if (roll < 95)
            begin
                queue_request(REQ_TICK, 16'($urandom_range(16'hFFFF, 0)),
                              16'($urandom_range(16'hFFFF, 0)));
                counted++;
            end
            else
            begin
                queue_request(REQ_NONE, 16'($urandom_range(16'hFFFF, 0)),
                              16'($urandom_range(16'hFFFF, 0)));
            end
        end
    endtask

    initial
    begin : stimulus
        int          counted;
        int          k;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_NONE;
        req_ch.duration  = 16'd0;
        req_ch.timer_id  = 16'd0;
        rsp_ch.ready     = 1'b0;
        armed            = 0;
        last_issued_id   = 16'd0;
        counted          = 0;

        // Directed part. A tick and deletes on the empty table, then zero and maximum
        // durations, a tie on equal times, and a tick that expires both timers due.
        queue_request(REQ_TICK, 16'd0, 16'd0);
        queue_request(REQ_DEL, 16'd0, 16'd0);
        queue_request(REQ_DEL, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_SET, 16'd0, 16'd0);
        queue_request(REQ_SET, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_SET, 16'd1, 16'd0);
        queue_request(REQ_SET, 16'd5, 16'd0);
        queue_request(REQ_SET, 16'd5, 16'd0);
        queue_request(REQ_DEL, 16'd0, 16'd4);
        queue_request(REQ_TICK, 16'd0, 16'd0);
        queue_request(REQ_NONE, 16'hFFFF, 16'hFFFF);
        queue_request(REQ_DEL, 16'd0, 16'd3);
        queue_request(REQ_TICK, 16'd0, 16'd0);
        // Fill the table with equal times, try one set too many, then expire the
        // whole group in one tick; the tie rule reverses their order.
        for (k = 0; k < DEPTH - 2; k++)
            queue_request(REQ_SET, 16'd1, 16'd0);
        queue_request(REQ_SET, 16'h8000, 16'd0);
        queue_request(REQ_TICK, 16'd0, 16'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait_until_drained();

        // Random part in batches; the sender holds off between batches until every
        // response has come back.
        while (counted < RANDOM_REQUESTS)
        begin
            queue_random_batch($urandom_range(40, 10), counted);
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("sorted_timer_queue: match");
        else
            $display("sorted_timer_queue: mismatch");
        $finish;
    end

endmodule
